[hw/rtl/susp_pkg.sv]
// Shared types and constants for the sorted unique set with prime index.
// No dependencies; used by the controller, datapath and top level.
package susp_pkg;

  localparam int unsigned CapacityDef   = 64;
  localparam int unsigned ValueWidthDef = 16;
  localparam int unsigned PosWidth      = 6;

  localparam logic [1:0] KindInsert = 2'd0;
  localparam logic [1:0] KindRemove = 2'd1;
  localparam logic [1:0] KindReadEl = 2'd2;
  localparam logic [1:0] KindReadPr = 2'd3;

  localparam logic [2:0] StDone     = 3'd0;
  localparam logic [2:0] StDup      = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StRange    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat, clear scan state
    logic scan;      // examine the entry at the scan index
    logic prime_go;  // start the trial-division test
    logic prime_step;// one bit step of the trial division
    logic shift_up;  // move entry idx-1 into idx, idx counts down
    logic shift_dn;  // move entry idx+1 into idx, idx counts up
    logic place;     // write the new value at the slot
    logic finish;    // update counts and raise the result strobe
  } susp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;   // scan index has reached the element count
    logic hit;        // search target met (value match, insert slot, position, or nth prime)
    logic prime_done; // trial division finished
    logic shift_end;  // shift pass complete
    logic rd_valid;   // registered memory read data is in place
    logic ins_skip;   // insert is a duplicate or the table is full
  } susp_sts_t;

endpackage

[hw/rtl/susp_ctrl.sv]
// Controller state machine for the sorted set.
// Depends on susp_pkg for the command and status structs.
module susp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          kind_i,
  input  susp_pkg::susp_sts_t sts_i,
  output susp_pkg::susp_cmd_t cmd_o,
  output logic                busy_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SPrime = 3'd2;
  localparam logic [2:0] SShift = 3'd3;
  localparam logic [2:0] SPlace = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;

  // State and captured kind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      kind_q  <= susp_pkg::KindInsert;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  assign busy_o = (state_q != SIdle);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          kind_d     = kind_i;
          state_d    = SScan;
        end
      end
      SScan: begin
        // One entry per cycle; memory read data arrives in the next cycle.
        if (sts_i.rd_valid && sts_i.hit) begin
          state_d = (kind_q == susp_pkg::KindInsert) ? SPrime :
                    (kind_q == susp_pkg::KindRemove) ? SShift : SDone;
          if (kind_q == susp_pkg::KindInsert) cmd_o.prime_go = 1'b1;
        end else if (sts_i.scan_end) begin
          state_d = (kind_q == susp_pkg::KindInsert) ? SPrime : SDone;
          if (kind_q == susp_pkg::KindInsert) cmd_o.prime_go = 1'b1;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      SPrime: begin
        // A duplicate or a full table leaves the table untouched.
        if (sts_i.prime_done) state_d = sts_i.ins_skip ? SDone : SShift;
        else cmd_o.prime_step = 1'b1;
      end
      SShift: begin
        if (sts_i.shift_end) begin
          state_d = (kind_q == susp_pkg::KindInsert) ? SPlace : SDone;
        end else if (kind_q == susp_pkg::KindInsert) begin
          cmd_o.shift_up = 1'b1;
        end else begin
          cmd_o.shift_dn = 1'b1;
        end
      end
      SPlace: begin
        cmd_o.place = 1'b1;
        state_d     = SDone;
      end
      SDone: begin
        cmd_o.finish = 1'b1;
        state_d      = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

[hw/rtl/susp_dp.sv]
// Datapath for the sorted set: value memory, flags, counts, divider.
// Depends on susp_pkg for codes and the command and status structs.
module susp_dp #(
  parameter int unsigned Capacity   = susp_pkg::CapacityDef,
  parameter int unsigned ValueWidth = susp_pkg::ValueWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  susp_pkg::susp_cmd_t          cmd_i,
  output susp_pkg::susp_sts_t          sts_o,
  input  logic [1:0]                   kind_i,
  input  logic signed [ValueWidth-1:0] value_i,
  input  logic [susp_pkg::PosWidth-1:0] position_i,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic [$clog2(Capacity+1)-1:0] element_count_o,
  output logic [$clog2(Capacity+1)-1:0] prime_count_o,
  output logic signed [ValueWidth-1:0] read_value_o,
  output logic                         read_is_prime_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned DW = ValueWidth / 2 + 1;
  localparam int unsigned BI = $clog2(ValueWidth);

  // Storage with one read and one write port: entry is value plus prime flag.
  logic [ValueWidth:0] mem [Capacity];

  logic [1:0]                   kind_q;
  logic signed [ValueWidth-1:0] val_q;
  logic [susp_pkg::PosWidth-1:0] pos_q;
  logic [CW-1:0] cnt_q, cnt_d, pcnt_q, pcnt_d;
  logic [CW-1:0] idx_q, idx_d;   // scan or shift index
  logic [CW-1:0] at_q, at_d;     // index of the entry being read
  logic [CW-1:0] seen_q, seen_d; // primes passed during a prime read
  logic          rdv_q, rdv_d;
  logic [ValueWidth:0] rd_q;
  logic          found_q, found_d;
  logic [CW-1:0] slot_q, slot_d;
  logic          isp_q, isp_d;
  logic          pdone_q, pdone_d;
  logic [DW-1:0] div_q, div_d;
  logic [ValueWidth-1:0] rem_q, rem_d;
  logic [DW-1:0] bit_q, bit_d;
  logic          done_q;
  logic [2:0]    st_q, st_d;
  logic signed [ValueWidth-1:0] rv_q, rv_d;
  logic          rp_q, rp_d;

  // Memory address selection.
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [ValueWidth:0] wr_data;
  logic          hit_c;
  logic          entry_p;
  logic signed [ValueWidth-1:0] entry_v;
  logic          full_c;
  logic          gt_one;

  assign entry_v = rd_q[ValueWidth-1:0];
  assign entry_p = rd_q[ValueWidth];
  assign full_c  = (cnt_q >= CW'(Capacity));
  assign gt_one  = (val_q > $signed(ValueWidth'(1)));

  always_comb begin
    rd_addr = idx_q[AW-1:0];
    if (cmd_i.shift_up) rd_addr = AW'(idx_q - CW'(1));
    if (cmd_i.shift_dn) rd_addr = AW'(idx_q + CW'(1));
  end

  // Writes come from the shift passes and the final placement; the shift
  // uses the entry read in the previous cycle, so the first step only reads.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = rd_q;
    if ((cmd_i.shift_up || cmd_i.shift_dn) && rdv_q) begin
      mem_we  = 1'b1;
      wr_addr = at_q[AW-1:0];
    end
    if (cmd_i.place) begin
      mem_we  = 1'b1;
      wr_addr = slot_q[AW-1:0];
      wr_data = {isp_q, val_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // Search hit for the current entry.
  always_comb begin
    unique case (kind_q)
      susp_pkg::KindInsert: hit_c = (entry_v >= val_q);
      susp_pkg::KindRemove: hit_c = (entry_v == val_q);
      susp_pkg::KindReadEl: hit_c = (at_q == CW'(pos_q));
      default:              hit_c = entry_p && (seen_q == CW'(pos_q));
    endcase
  end

  // The shift ends once the last pending write has gone out.
  assign sts_o.rd_valid   = rdv_q;
  assign sts_o.hit        = hit_c;
  assign sts_o.scan_end   = (idx_q >= cnt_q);
  assign sts_o.prime_done = pdone_q;
  assign sts_o.ins_skip   = found_q || full_c;
  assign sts_o.shift_end  = !rdv_q && ((kind_q == susp_pkg::KindInsert) ?
                            (idx_q <= slot_q) : (idx_q >= cnt_q - CW'(1)));

  logic [2*DW-1:0] sq;
  logic [ValueWidth-1:0] uval;
  logic [BI-1:0] bit_idx;
  logic [ValueWidth-1:0] shifted;
  assign sq      = div_q * div_q;
  assign uval    = val_q;
  assign bit_idx = BI'(bit_q - DW'(1));
  assign shifted = {rem_q[ValueWidth-2:0], uval[bit_idx]};

  // Control and datapath registers.
  always_comb begin
    idx_d = idx_q; at_d = at_q; seen_d = seen_q; rdv_d = 1'b0;
    found_d = found_q; slot_d = slot_q; isp_d = isp_q; pdone_d = pdone_q;
    div_d = div_q; rem_d = rem_q; bit_d = bit_q;
    cnt_d = cnt_q; pcnt_d = pcnt_q; st_d = st_q; rv_d = rv_q; rp_d = rp_q;
    if (cmd_i.load) begin
      idx_d = '0; seen_d = '0; found_d = 1'b0; slot_d = cnt_q;
      st_d = susp_pkg::StDone; rv_d = '0; rp_d = 1'b0;
    end
    if (cmd_i.scan) begin
      at_d  = idx_q;
      idx_d = idx_q + CW'(1);
      rdv_d = 1'b1;
    end
    // Evaluate a read result from the previous scan step.
    if (rdv_q && !cmd_i.shift_up && !cmd_i.shift_dn) begin
      if (entry_p) seen_d = seen_q + CW'(1);
      if (hit_c) begin
        slot_d = at_q;
        found_d = (kind_q != susp_pkg::KindInsert) || (entry_v == val_q);
        if (kind_q[1]) begin
          rv_d = entry_v; rp_d = entry_p;
        end
        if (kind_q == susp_pkg::KindRemove) begin
          idx_d = at_q;
          if (entry_p) pcnt_d = pcnt_q - CW'(1);
        end
      end
    end
    if (cmd_i.prime_go) begin
      // Trial division starts at 2; duplicates, full and values below 2 skip the work.
      div_d = DW'(2);
      isp_d = gt_one;
      pdone_d = found_d || full_c || !gt_one;
      rem_d = '0; bit_d = DW'(ValueWidth);
      idx_d = cnt_q;
      st_d = found_d ? susp_pkg::StDup : full_c ? susp_pkg::StFull : susp_pkg::StDone;
    end
    if (cmd_i.prime_step) begin
      // Bit-serial restoring remainder of value by div, one bit a cycle.
      if (bit_q == '0) begin
        if (rem_q == '0) begin
          isp_d = 1'b0; pdone_d = 1'b1;
        end else begin
          div_d = div_q + DW'(1); rem_d = '0; bit_d = DW'(ValueWidth);
        end
      end else if (sq > (2*DW)'(uval)) begin
        pdone_d = 1'b1;
      end else begin
        bit_d = bit_q - DW'(1);
        rem_d = (shifted >= ValueWidth'(div_q)) ? shifted - ValueWidth'(div_q) : shifted;
      end
    end
    if (cmd_i.shift_up) begin
      at_d = idx_q; rdv_d = (idx_q > slot_q);
      if (idx_q > slot_q) idx_d = idx_q - CW'(1);
    end
    if (cmd_i.shift_dn) begin
      at_d = idx_q; idx_d = idx_q + CW'(1); rdv_d = (idx_q < cnt_q - CW'(1));
    end
    if (cmd_i.place) begin
      cnt_d = cnt_q + CW'(1);
      if (isp_q) pcnt_d = pcnt_q + CW'(1);
    end
    if (cmd_i.finish) begin
      unique case (kind_q)
        susp_pkg::KindInsert: st_d = st_q;
        susp_pkg::KindRemove: st_d = found_q ? susp_pkg::StDone : susp_pkg::StNotFound;
        default: st_d = found_q ? susp_pkg::StDone : susp_pkg::StRange;
      endcase
      if (kind_q == susp_pkg::KindRemove && found_q) cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; pcnt_q <= '0; rdv_q <= 1'b0; done_q <= 1'b0;
      idx_q <= '0; at_q <= '0; seen_q <= '0; found_q <= 1'b0; slot_q <= '0;
      isp_q <= 1'b0; pdone_q <= 1'b0; div_q <= '0; rem_q <= '0; bit_q <= '0;
      st_q <= '0; rv_q <= '0; rp_q <= 1'b0; kind_q <= '0;
    end else begin
      cnt_q <= cnt_d; pcnt_q <= pcnt_d; rdv_q <= rdv_d; done_q <= cmd_i.finish;
      idx_q <= idx_d; at_q <= at_d; seen_q <= seen_d; found_q <= found_d;
      slot_q <= slot_d; isp_q <= isp_d; pdone_q <= pdone_d; div_q <= div_d;
      rem_q <= rem_d; bit_q <= bit_d; st_q <= st_d; rv_q <= rv_d; rp_q <= rp_d;
      if (cmd_i.load) kind_q <= kind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= value_i;
      pos_q <= position_i;
    end
  end

  assign done_o          = done_q;
  assign status_o        = st_q;
  assign element_count_o = cnt_q;
  assign prime_count_o   = pcnt_q;
  assign read_value_o    = rv_q;
  assign read_is_prime_o = rp_q;

endmodule

[hw/rtl/sorted_unique_set_with_prime_index.sv]
// Sorted set of distinct signed values with per-entry prime flags.
// An insert also runs a trial division, divisor by divisor, which is skipped
// for a duplicate, a full table or a value below 2.
// One beat at a time; busy is low again in the cycle of the strobe.
// Reset clears the counts; table entries are undefined until written; no stall.
module sorted_unique_set_with_prime_index #(
  parameter int unsigned Capacity   = susp_pkg::CapacityDef,
  parameter int unsigned ValueWidth = susp_pkg::ValueWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic signed [ValueWidth-1:0]  value_i,
  input  logic [susp_pkg::PosWidth-1:0] position_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [$clog2(Capacity+1)-1:0] element_count_o,
  output logic [$clog2(Capacity+1)-1:0] prime_count_o,
  output logic signed [ValueWidth-1:0]  read_value_o,
  output logic                          read_is_prime_o
);

  susp_pkg::susp_cmd_t cmd;
  susp_pkg::susp_sts_t sts;

  susp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .kind_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  susp_dp #(.Capacity(Capacity), .ValueWidth(ValueWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .kind_i, .value_i, .position_i,
    .done_o, .status_o, .element_count_o, .prime_count_o,
    .read_value_o, .read_is_prime_o
  );

endmodule

[verif/sorted_unique_set_with_prime_index_test.sv]
// Self-checking testbench for the sorted unique set with prime index.
// Depends on susp_pkg and the sorted_unique_set_with_prime_index top level.
`timescale 1ns / 1ps

module sorted_unique_set_with_prime_index_test;

  localparam int unsigned Depth       = 64;
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned DrainCycles = 4000;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] value;
    logic [5:0]         position;
    int unsigned        gap_pct;
  } set_op_t;

  typedef struct {
    logic [2:0]         status;
    logic [6:0]         element_count;
    logic [6:0]         prime_count;
    logic signed [15:0] read_value;
    logic               read_is_prime;
  } set_reply_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         kind_i;
  logic signed [15:0] value_i;
  logic [5:0]         position_i;
  logic               done_o;
  logic [2:0]         status_o;
  logic [6:0]         element_count_o;
  logic [6:0]         prime_count_o;
  logic signed [15:0] read_value_o;
  logic               read_is_prime_o;

  set_op_t     pending_ops[$];
  set_reply_t  expected_replies[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic        presenting;

  // Shadow copy of the table held in ascending order.
  logic signed [15:0] shadow_vals[Depth];
  logic               shadow_prime[Depth];
  int unsigned        shadow_count = 0;
  int unsigned        shadow_primes = 0;

  sorted_unique_set_with_prime_index dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .prime_count_o   (prime_count_o),
    .read_value_o    (read_value_o),
    .read_is_prime_o (read_is_prime_o)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Trial division: prime when at least 2 and no divisor up to the square root.
  function automatic logic is_prime_value(logic signed [15:0] v);
    int n;
    n = int'(v);
    if (n < 2) return 1'b0;
    for (int d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one operation to the shadow table and returns the reply it gives.
  function automatic set_reply_t apply_set_op(set_op_t op);
    set_reply_t r;
    int         at;
    int         slot;
    int         seen;
    r.status        = susp_pkg::StDone;
    r.read_value    = '0;
    r.read_is_prime = 1'b0;
    at = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (at < 0 && shadow_vals[i] == op.value) at = i;
    end
    case (op.kind)
      susp_pkg::KindInsert: begin
        if (at >= 0) begin
          r.status = susp_pkg::StDup;
        end else if (shadow_count >= Depth) begin
          r.status = susp_pkg::StFull;
        end else begin
          slot = 0;
          while (slot < shadow_count && shadow_vals[slot] < op.value) slot++;
          for (int i = shadow_count; i > slot; i--) begin
            shadow_vals[i]  = shadow_vals[i-1];
            shadow_prime[i] = shadow_prime[i-1];
          end
          shadow_vals[slot]  = op.value;
          shadow_prime[slot] = is_prime_value(op.value);
          if (shadow_prime[slot]) shadow_primes++;
          shadow_count++;
        end
      end
      susp_pkg::KindRemove: begin
        if (at < 0) begin
          r.status = susp_pkg::StNotFound;
        end else begin
          if (shadow_prime[at]) shadow_primes--;
          for (int i = at; i + 1 < shadow_count; i++) begin
            shadow_vals[i]  = shadow_vals[i+1];
            shadow_prime[i] = shadow_prime[i+1];
          end
          shadow_count--;
        end
      end
      susp_pkg::KindReadEl: begin
        if (op.position >= shadow_count) begin
          r.status = susp_pkg::StRange;
        end else begin
          r.read_value    = shadow_vals[op.position];
          r.read_is_prime = shadow_prime[op.position];
        end
      end
      default: begin
        r.status = susp_pkg::StRange;
        seen = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_prime[i] && r.status == susp_pkg::StRange) begin
            if (seen == op.position) begin
              r.read_value    = shadow_vals[i];
              r.read_is_prime = 1'b1;
              r.status        = susp_pkg::StDone;
            end
            seen++;
          end
        end
      end
    endcase
    r.element_count = shadow_count[6:0];
    r.prime_count   = shadow_primes[6:0];
    return r;
  endfunction

  // Driver: presents the head of the queue and pops it once the beat is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      kind_i     <= susp_pkg::KindReadEl;
      value_i    <= '0;
      position_i <= '0;
      presenting = 1'b0;
    end else begin
      if (start && !busy) begin
        expected_replies.insert(expected_replies.size(),
                                apply_set_op(pending_ops.pop_front()));
        presenting = 1'b0;
      end
      if (!presenting && pending_ops.size() > 0 &&
          $urandom_range(0, 99) >= pending_ops[0].gap_pct) begin
        presenting = 1'b1;
        kind_i     <= pending_ops[0].kind;
        value_i    <= pending_ops[0].value;
        position_i <= pending_ops[0].position;
      end
      start <= presenting;
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    set_reply_t want;
    if (rst_ni && done_o) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: status %0d", status_o);
      end else begin
        want = expected_replies.pop_front();
        if (status_o !== want.status || element_count_o !== want.element_count ||
            prime_count_o !== want.prime_count || read_value_o !== want.read_value ||
            read_is_prime_o !== want.read_is_prime) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected st %0d n %0d p %0d v %0d f %0d",
                     want.status, want.element_count, want.prime_count,
                     want.read_value, want.read_is_prime);
            $display("          actual   st %0d n %0d p %0d v %0d f %0d",
                     status_o, element_count_o, prime_count_o,
                     read_value_o, read_is_prime_o);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_op(logic [1:0] k, int v, int p, int unsigned pct);
    set_op_t op;
    op.kind     = k;
    op.value    = 16'(v);
    op.position = 6'(p);
    op.gap_pct  = pct;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  initial begin
    int big_primes[6];
    int pct;
    int roll;
    int v;
    int p;
    logic [1:0] k;
    big_primes = '{32749, 32719, 30011, 16381, 257, 7919};
    rst_ni = 1'b0;

    // Directed part: field extremes, every operation and each corner case.
    queue_op(susp_pkg::KindReadEl, 0, 0, 0);
    queue_op(susp_pkg::KindReadPr, 0, 0, 0);
    queue_op(susp_pkg::KindRemove, 5, 0, 0);
    queue_op(susp_pkg::KindInsert, 0, 0, 0);
    queue_op(susp_pkg::KindInsert, -32768, 0, 0);
    queue_op(susp_pkg::KindInsert, 32767, 0, 0);
    queue_op(susp_pkg::KindInsert, 2, 0, 0);
    queue_op(susp_pkg::KindInsert, 3, 0, 0);
    queue_op(susp_pkg::KindInsert, 1, 0, 0);
    queue_op(susp_pkg::KindInsert, 4, 0, 0);
    queue_op(susp_pkg::KindInsert, 32749, 0, 0);
    queue_op(susp_pkg::KindInsert, -7, 0, 0);
    queue_op(susp_pkg::KindInsert, 2, 0, 0);
    queue_op(susp_pkg::KindReadEl, 0, 0, 0);
    queue_op(susp_pkg::KindReadEl, 0, 8, 0);
    queue_op(susp_pkg::KindReadEl, 0, 9, 0);
    queue_op(susp_pkg::KindReadEl, 0, 63, 0);
    queue_op(susp_pkg::KindReadPr, 0, 2, 0);
    queue_op(susp_pkg::KindReadPr, 0, 3, 0);
    queue_op(susp_pkg::KindRemove, 2, 0, 0);
    queue_op(susp_pkg::KindReadPr, 0, 0, 0);
    queue_op(susp_pkg::KindRemove, -32768, 0, 0);
    queue_op(susp_pkg::KindRemove, 4, 0, 0);

    // Random part in stretches that alternately fill and drain the table.
    for (int i = 0; i < 500; i++) begin
      if (i < 100) pct = 0;
      else if (i < 250) pct = 69;
      else if (i < 350) pct = 0;
      else pct = 10;
      roll = int'($urandom_range(0, 99));
      if ((i / 80) % 2 == 0) begin
        k = roll < 60 ? susp_pkg::KindInsert : roll < 70 ? susp_pkg::KindRemove :
            roll < 85 ? susp_pkg::KindReadEl : susp_pkg::KindReadPr;
      end else begin
        k = roll < 25 ? susp_pkg::KindInsert : roll < 70 ? susp_pkg::KindRemove :
            roll < 85 ? susp_pkg::KindReadEl : susp_pkg::KindReadPr;
      end
      roll = int'($urandom_range(0, 99));
      if (roll < 75) v = int'($urandom_range(0, 200)) - 50;
      else if (roll < 85) v = big_primes[$urandom_range(0, 5)];
      else v = int'($signed(16'($urandom)));
      p = $urandom_range(0, 1) ? int'($urandom_range(0, 63)) : int'($urandom_range(0, 15));
      queue_op(k, v, p, pct);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_ops.size() == 0 && expected_replies.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/susp_pkg.sv
hw/rtl/susp_ctrl.sv
hw/rtl/susp_dp.sv
hw/rtl/sorted_unique_set_with_prime_index.sv
verif/sorted_unique_set_with_prime_index_test.sv
